>>> rtl/assert_macros.svh
// Assertion helpers used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFLA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SFLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFLA_ASSERT(lbl, clk, rstn, prop, msg)
`define SFLA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/sfla_pkg.sv
`timescale 1ns / 1ps
package sfla_pkg;
  localparam int unsigned SEGMENTS      = 2;
  localparam int unsigned BIG_SIZE      = 20;
  localparam int unsigned SEGMENT_WORDS = 65536;
  localparam int unsigned MIN_CHUNK     = 2;

  localparam int unsigned LOC_W     = 16;
  localparam int unsigned SEG_W     = 1;
  localparam int unsigned SEGI_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned LISTS     = BIG_SIZE + 1;
  localparam int unsigned HEADS     = SEGMENTS * LISTS;
  localparam int unsigned HEAD_AW   = $clog2(HEADS);
  localparam int unsigned HEAP_AW   = SEGI_W + LOC_W;
  localparam int unsigned HEAP_DEPTH = 1 << HEAP_AW;
  localparam int unsigned K_W       = $clog2(BIG_SIZE + 1);
  localparam int unsigned STEP_W    = $clog2(SEGMENT_WORDS + 1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_RDH,
    OP_PUSH_WSZ,
    OP_PUSH_WLK,
    OP_RD_HEAD,
    OP_TAKE_HEAD,
    OP_NEXT_LIST,
    OP_RD_SIZE,
    OP_RD_NEXT,
    OP_UNLINK,
    OP_ADVANCE,
    OP_RESP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_bad;
    logic walk_end;
    logic last_list;
    logic fit;
    logic split;
    logic out_busy;
  } dp_stat_t;
endpackage

>>> rtl/sfla_intf.sv
`timescale 1ns / 1ps
interface sfla_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] size_words;
  logic        seg_in;
  logic [15:0] loc_in;

  modport source (output valid, func, size_words, seg_in, loc_in, input ready);
  modport sink (input valid, func, size_words, seg_in, loc_in, output ready);
endinterface

interface sfla_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        seg_out;
  logic [15:0] loc_out;

  modport source (output valid, ok, seg_out, loc_out, input ready);
  modport sink (input valid, ok, seg_out, loc_out, output ready);
endinterface

>>> rtl/sfla_ctrl.sv
`timescale 1ns / 1ps
module sfla_ctrl import sfla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  logic     rsp_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PUSH_RDH, S_PUSH_WSZ, S_PUSH_WLK,
    S_LIST_RDH, S_LIST_GETH, S_WALK_CHK, S_WALK_RDN, S_WALK_FIT, S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_free) begin
          state_d = stat_i.free_bad ? S_RESP : S_PUSH_RDH;
        end else begin
          state_d = S_LIST_RDH;
        end
      end
      S_PUSH_RDH: begin
        cmd_o.op = OP_PUSH_RDH;
        state_d  = S_PUSH_WSZ;
      end
      S_PUSH_WSZ: begin
        cmd_o.op = OP_PUSH_WSZ;
        state_d  = S_PUSH_WLK;
      end
      S_PUSH_WLK: begin
        cmd_o.op = OP_PUSH_WLK;
        state_d  = S_RESP;
      end
      S_LIST_RDH: begin
        cmd_o.op = OP_RD_HEAD;
        state_d  = S_LIST_GETH;
      end
      S_LIST_GETH: begin
        cmd_o.op = OP_TAKE_HEAD;
        state_d  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (stat_i.walk_end) begin
          if (stat_i.last_list) begin
            state_d = S_RESP;
          end else begin
            cmd_o.op = OP_NEXT_LIST;
            state_d  = S_LIST_RDH;
          end
        end else begin
          cmd_o.op = OP_RD_SIZE;
          state_d  = S_WALK_RDN;
        end
      end
      S_WALK_RDN: begin
        cmd_o.op = OP_RD_NEXT;
        state_d  = S_WALK_FIT;
      end
      S_WALK_FIT: begin
        if (stat_i.fit) begin
          cmd_o.op = OP_UNLINK;
          state_d  = stat_i.split ? S_PUSH_RDH : S_RESP;
        end else begin
          cmd_o.op = OP_ADVANCE;
          state_d  = S_WALK_CHK;
        end
      end
      S_RESP: begin
        if (!stat_i.out_busy || rsp_ready_i) begin
          cmd_o.op = OP_RESP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> rtl/sfla_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfla_dpath import sfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic              func_i,
  input  logic [LOC_W-1:0]  size_words_i,
  input  logic [SEG_W-1:0]  seg_in_i,
  input  logic [LOC_W-1:0]  loc_in_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output logic              ok_o,
  output logic [SEG_W-1:0]  seg_out_o,
  output logic [LOC_W-1:0]  loc_out_o
);
  logic [LOC_W-1:0]  head_mem [HEADS];
  logic [HEADS-1:0]  head_vld_q;
  logic [LOC_W-1:0]  head_rd_q;
  logic              head_rdv_q;
  logic [LOC_W-1:0]  head_val;

  logic [LOC_W-1:0]  heap_mem [HEAP_DEPTH];
  logic [LOC_W-1:0]  heap_rd_q;

  logic              func_q, free_bad_q;
  logic [LOC_W-1:0]  words_q, loc_q, prev_q, size_q;
  logic [K_W-1:0]    k_q, first_q;
  logic [SEGI_W-1:0] cseg_q, pseg_q;
  logic [LOC_W-1:0]  ploc_q, psize_q;
  logic [STEP_W-1:0] steps_q;
  logic              res_ok_q;
  logic [SEG_W-1:0]  res_seg_q;
  logic [LOC_W-1:0]  res_loc_q;
  logic              out_valid_q, ok_q;
  logic [SEG_W-1:0]  seg_q;
  logic [LOC_W-1:0]  out_loc_q;

  logic [LOC_W-1:0]   in_words;
  logic [K_W-1:0]     in_first;
  logic [LOC_W:0]     chunk_end;
  logic               in_bad;
  logic [K_W-1:0]     walk_list, push_list;
  logic [HEAD_AW-1:0] walk_haddr, push_haddr;
  logic [LOC_W-1:0]   rest, tail;
  logic [LOC_W:0]     words_p2;

  logic               head_we, head_re, heap_we, heap_re;
  logic [HEAD_AW-1:0] head_waddr, head_raddr;
  logic [LOC_W-1:0]   head_wdata, heap_wdata;
  logic [HEAP_AW-1:0] heap_waddr, heap_raddr;

  assign in_words = (size_words_i < LOC_W'(MIN_CHUNK)) ? LOC_W'(MIN_CHUNK) : size_words_i;
  assign in_first = (in_words < LOC_W'(BIG_SIZE)) ? in_words[K_W-1:0] : K_W'(BIG_SIZE);
  assign chunk_end = {1'b0, loc_in_i} + {1'b0, size_words_i};
  assign in_bad   = (size_words_i < LOC_W'(MIN_CHUNK)) || (loc_in_i == '0) ||
                    (32'(seg_in_i) >= SEGMENTS) || (32'(chunk_end) > SEGMENT_WORDS);

  assign walk_list  = (k_q == K_W'(BIG_SIZE)) ? '0 : k_q;
  assign push_list  = (psize_q >= LOC_W'(BIG_SIZE)) ? '0 : psize_q[K_W-1:0];
  assign walk_haddr = HEAD_AW'(HEAD_AW'(cseg_q) * HEAD_AW'(LISTS)) + HEAD_AW'(walk_list);
  assign push_haddr = HEAD_AW'(HEAD_AW'(pseg_q) * HEAD_AW'(LISTS)) + HEAD_AW'(push_list);
  assign head_val   = head_rdv_q ? head_rd_q : '0;

  assign rest     = size_q - words_q;
  assign tail     = loc_q + words_q;
  assign words_p2 = {1'b0, words_q} + (LOC_W+1)'(MIN_CHUNK);

  assign stat_o.is_free   = (func_q == FUNC_FREE);
  assign stat_o.free_bad  = free_bad_q;
  assign stat_o.walk_end  = (loc_q == '0) || (steps_q == STEP_W'(SEGMENT_WORDS));
  assign stat_o.last_list = (k_q == K_W'(BIG_SIZE)) && (cseg_q == SEGI_W'(SEGMENTS - 1));
  assign stat_o.fit       = (size_q == words_q) || ({1'b0, size_q} >= words_p2);
  assign stat_o.split     = (rest >= LOC_W'(MIN_CHUNK)) && (tail != '0);
  assign stat_o.out_busy  = out_valid_q;

  // Memory port steering.
  always_comb begin
    head_re    = 1'b0;
    head_raddr = walk_haddr;
    head_we    = 1'b0;
    head_waddr = push_haddr;
    head_wdata = ploc_q;
    heap_re    = 1'b0;
    heap_raddr = {cseg_q, loc_q};
    heap_we    = 1'b0;
    heap_waddr = {pseg_q, ploc_q};
    heap_wdata = psize_q;
    case (cmd_i.op)
      OP_RD_HEAD:  head_re = 1'b1;
      OP_PUSH_RDH: begin
        head_re    = 1'b1;
        head_raddr = push_haddr;
      end
      OP_PUSH_WSZ: heap_we = 1'b1;
      OP_PUSH_WLK: begin
        heap_we    = 1'b1;
        heap_waddr = {pseg_q, ploc_q + LOC_W'(1)};
        heap_wdata = head_val;
        head_we    = 1'b1;
      end
      OP_RD_SIZE:  heap_re = 1'b1;
      OP_RD_NEXT: begin
        heap_re    = 1'b1;
        heap_raddr = {cseg_q, loc_q + LOC_W'(1)};
      end
      OP_UNLINK: begin
        if (prev_q == '0) begin
          head_we    = 1'b1;
          head_waddr = walk_haddr;
          head_wdata = heap_rd_q;
        end else begin
          heap_we    = 1'b1;
          heap_waddr = {cseg_q, prev_q + LOC_W'(1)};
          heap_wdata = heap_rd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_rd_q <= head_mem[head_raddr];
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (heap_re) heap_rd_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      head_rdv_q <= 1'b0;
    end else begin
      if (head_we) head_vld_q[head_waddr] <= 1'b1;
      if (head_re) head_rdv_q <= head_vld_q[head_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESP) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q     <= func_i;
        free_bad_q <= in_bad;
        words_q    <= in_words;
        first_q    <= in_first;
        k_q        <= in_first;
        cseg_q     <= '0;
        pseg_q     <= SEGI_W'(seg_in_i);
        ploc_q     <= loc_in_i;
        psize_q    <= size_words_i;
        res_ok_q   <= 1'b0;
        res_seg_q  <= '0;
        res_loc_q  <= '0;
      end
      OP_TAKE_HEAD: begin
        loc_q   <= head_val;
        prev_q  <= '0;
        steps_q <= '0;
      end
      OP_NEXT_LIST: begin
        if (k_q == K_W'(BIG_SIZE)) begin
          cseg_q <= cseg_q + SEGI_W'(1);
          k_q    <= first_q;
        end else begin
          k_q <= k_q + K_W'(1);
        end
      end
      OP_RD_NEXT: size_q <= heap_rd_q;
      OP_ADVANCE: begin
        prev_q  <= loc_q;
        loc_q   <= heap_rd_q;
        steps_q <= steps_q + STEP_W'(1);
      end
      OP_UNLINK: begin
        res_ok_q  <= 1'b1;
        res_seg_q <= cseg_q[SEG_W-1:0];
        res_loc_q <= loc_q;
        pseg_q    <= cseg_q;
        ploc_q    <= tail;
        psize_q   <= rest;
      end
      OP_PUSH_WLK: res_ok_q <= 1'b1;
      OP_RESP: begin
        ok_q      <= res_ok_q;
        seg_q     <= res_seg_q;
        out_loc_q <= res_loc_q;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign seg_out_o   = seg_q;
  assign loc_out_o   = out_loc_q;

  `SFLA_ASSERT(a_resp_no_overwrite, clk_i, rst_ni, (cmd_i.op == OP_RESP) |-> (!out_valid_q || rsp_ready_i), "result overwritten before transfer")
  `SFLA_ASSERT(a_steps_bound, clk_i, rst_ni, (steps_q <= STEP_W'(SEGMENT_WORDS)) || (cmd_i.op != OP_ADVANCE), "walk step count past bound")
  `SFLA_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_q && !ok_q) |-> (out_loc_q == '0 && seg_q == '0), "failed result carries a location")
  `SFLA_ASSERT(a_unlink_nonzero, clk_i, rst_ni, (cmd_i.op == OP_UNLINK) |-> (loc_q != '0), "unlink of an empty list")
endmodule

>>> rtl/segregated_free_list_allocator.sv
`timescale 1ns / 1ps
// Segregated-fit heap allocator. Each request transfer (func 0 allocate,
// func 1 free) yields exactly one response transfer. Free chunks are threaded
// through the heap memory (word 0 size, word 1 next link, link 0 ends a list);
// each segment keeps one list per exact size below the big size plus one list
// of big chunks. Items are processed one at a time; the request side reopens
// once the result is parked in the response register, so a pending response
// never blocks the next request. A free loads, reads the list head, writes the
// size and link words, then responds; a rejected free goes straight to the
// response. An allocate reads each list head visited and the size and next
// link of each chunk inspected, then pushes any split tail back as a free does;
// the linked-list heap walk (one header word per read) sets its duration. The
// list heads need no clearing pass: per-head valid bits read unwritten heads
// as empty. Heap words that were never written are not cleared.
module segregated_free_list_allocator import sfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfla_req_if.sink          req_i,
  sfla_rsp_if.source        rsp_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: walks lists, issuing at most one datapath step per cycle.
  sfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: list heads, heap memory, walk registers, response register.
  sfla_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (req_i.func),
    .size_words_i (req_i.size_words),
    .seg_in_i     (req_i.seg_in),
    .loc_in_i     (req_i.loc_in),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .ok_o         (rsp_o.ok),
    .seg_out_o    (rsp_o.seg_out),
    .loc_out_o    (rsp_o.loc_out)
  );
endmodule
